/* rtl/integer_to_decimal_ascii_macros.svh */
// Assertion macros shared by the integer to decimal ASCII block.
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define I2DA_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("integer_to_decimal_ascii: assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define I2DA_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("integer_to_decimal_ascii: assertion failed");

`endif

/* rtl/i2da_pkg.sv */
// Types and constants shared by the integer to decimal ASCII modules.
package i2da_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
  localparam int unsigned BITCNT_W  = 7;
  localparam int unsigned DIGCNT_W  = 5;

  localparam logic [BITCNT_W-1:0] BITS_LONG  = 7'd64;
  localparam logic [BITCNT_W-1:0] BITS_SHORT = 7'd32;
  localparam logic [DIGCNT_W-1:0] DIGITS_ALL = 5'd20;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [3:0] DIGIT_ADJ     = 4'd3;

  localparam logic CMD_SIGNED   = 1'b0;
  localparam logic CMD_UNSIGNED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic emit_prefix;
    logic digit_step;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shift_done;
    logic prefix_valid;
    logic top_zero;
    logic last_digit;
  } status_t;

endpackage

/* rtl/i2da_dpath.sv */
// Datapath: magnitude and sign prefix, double-dabble BCD register and character output.
module i2da_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  i2da_pkg::cmd_t                  cmd,
  input  logic                            command,
  input  logic [i2da_pkg::VALUE_W-1:0]    value,
  input  logic                            is_long,
  input  logic                            plus_flag,
  input  logic                            space_flag,
  output i2da_pkg::status_t               status,
  output logic                            strobe,
  output logic [7:0]                      char_out,
  output logic                            last_char
);
  import i2da_pkg::*;

  logic [VALUE_W-1:0]  mag;
  logic [BCD_W-1:0]    bcd;
  logic [BITCNT_W-1:0] bit_cnt;
  logic [DIGCNT_W-1:0] dig_cnt;
  logic                prefix_valid;
  logic [7:0]          prefix_char;

  logic                neg;
  logic [HALF_W-1:0]   low_mag;
  logic [VALUE_W-1:0]  mag_load;
  logic [BCD_W-1:0]    bcd_adj;
  logic [3:0]          top_digit;

  always_comb begin
    if (is_long) begin
      neg      = (command == CMD_SIGNED) && value[VALUE_W-1];
      low_mag  = '0;
      mag_load = neg ? (~value + 64'd1) : value;
    end else begin
      neg      = (command == CMD_SIGNED) && value[HALF_W-1];
      low_mag  = neg ? (~value[HALF_W-1:0] + 32'd1) : value[HALF_W-1:0];
      // A short operand is left-aligned so that 32 shifts clear it out.
      mag_load = {low_mag, {HALF_W{1'b0}}};
    end
  end

  // Add three to every digit of five or more before each shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= DIGIT_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + DIGIT_ADJ;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag     <= mag_load;
      bcd     <= '0;
      bit_cnt <= is_long ? BITS_LONG : BITS_SHORT;
      dig_cnt <= DIGITS_ALL;
      if (neg) begin
        prefix_char <= CH_MINUS;
      end else if (plus_flag) begin
        prefix_char <= CH_PLUS;
      end else begin
        prefix_char <= CH_SPACE;
      end
    end else if (cmd.shift) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt - 7'd1;
    end else if (cmd.digit_step) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_cnt <= dig_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_valid <= 1'b0;
    end else if (cmd.load) begin
      prefix_valid <= neg || ((command == CMD_SIGNED) && (plus_flag || space_flag));
    end else if (cmd.emit_prefix) begin
      prefix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_prefix || cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    char_out  <= cmd.emit_prefix ? prefix_char : (CH_ZERO | {4'd0, top_digit});
    last_char <= cmd.emit_digit && (dig_cnt == 5'd1);
  end

  assign status.shift_done   = (bit_cnt == 7'd1);
  assign status.prefix_valid = prefix_valid;
  assign status.top_zero     = (top_digit == 4'd0);
  assign status.last_digit   = (dig_cnt == 5'd1);

endmodule

/* rtl/i2da_ctrl.sv */
// Controller: sequences load, binary to BCD shifting and digit emission.
module i2da_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  i2da_pkg::status_t status,
  output i2da_pkg::cmd_t    cmd,
  output logic              busy
);
  import i2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       started;
  logic       started_next;

  always_comb begin
    state_next   = state;
    started_next = started;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          started_next = 1'b0;
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift       = 1'b1;
        cmd.emit_prefix = status.prefix_valid;
        if (status.shift_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Leading zero digits are stepped past without a word; the units digit always goes out.
        cmd.digit_step = 1'b1;
        cmd.emit_digit = started || !status.top_zero || status.last_digit;
        if (cmd.emit_digit) begin
          started_next = 1'b1;
        end
        if (status.last_digit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

/* rtl/integer_to_decimal_ascii.sv */
// Top level of the integer to decimal ASCII converter.
// A number is taken when start is high and busy is low; busy then stays high until its last
// digit has been stepped out, so a new number is taken only after the last one is done. Busy
// covers the double-dabble loop, which moves one bit of the magnitude into the BCD
// register per cycle, and then a pass that steps through all 20 BCD digits, skipping
// leading zeros. Each text word (sign or space prefix, then the digits) appears for exactly
// one cycle with strobe high, and last_char marks the final word; the receiver cannot stall,
// so it must take every word as it comes.
`include "integer_to_decimal_ascii_macros.svh"

module integer_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [i2da_pkg::VALUE_W-1:0] value,
  input  logic                         is_long,
  input  logic                         plus_flag,
  input  logic                         space_flag,
  output logic                         strobe,
  output logic [7:0]                   char_out,
  output logic                         last_char
);
  import i2da_pkg::*;

  cmd_t    cmd;
  status_t status;

  i2da_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  i2da_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .command    (command),
    .value      (value),
    .is_long    (is_long),
    .plus_flag  (plus_flag),
    .space_flag (space_flag),
    .status     (status),
    .strobe     (strobe),
    .char_out   (char_out),
    .last_char  (last_char)
  );

  `I2DA_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
  `I2DA_ASSERT_NEXT(a_gap_after_last, strobe && last_char, !strobe)
  `I2DA_ASSERT_IMP(a_word_from_busy, strobe, $past(busy))

endmodule
